// File: rtl/efrs_pkg.sv
// Shared types and constants of the epoch flow rotation scheduler.
`default_nettype none

package efrs_pkg;

   // Widths of the item and result fields.
   localparam int ACTION_W = 2;
   localparam int FLOW_W   = 8;
   localparam int CMD_W    = 3;
   localparam int LIMIT_W  = 6;

   // The live map covers every flow identifier.
   localparam int LIVE_DEPTH = 1 << FLOW_W;

   // Actions carried by an input item.
   localparam logic [ACTION_W-1:0] ACTION_OPEN  = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_CLOSE = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_TICK  = 2'd2;

   // Commands carried by a result item.
   typedef enum logic [CMD_W-1:0] {
      CMD_PLACED   = 3'd0,
      CMD_PAUSE    = 3'd1,
      CMD_ACTIVATE = 3'd2,
      CMD_RELEASED = 3'd3,
      CMD_REJECTED = 3'd4
   } command_type;

endpackage : efrs_pkg

`default_nettype wire

// File: rtl/efrs_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module efrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : efrs_ram

`default_nettype wire

// File: rtl/epoch_flow_rotation_scheduler.sv
// Top level of the epoch flow rotation scheduler: control sequencer and its three RAMs.
// A close gives its result in the cycle after acceptance; an open passes through ST_OPEN before its result.
// A tick stays busy while it walks the paused entries and then the previously active entries,
// each walked entry costing one RAM read, one live-map read and one decision step.
// A close leaves busy low; an open holds busy for one cycle; a tick with nothing to do none.
// Results cannot be stalled. Reset empties both FIFOs, clears every live bit at once
// and sets the limit to 1; RAM contents are not cleared and need no clearing pass.
`default_nettype none

module epoch_flow_rotation_scheduler #(
   parameter int FLOW_SLOTS = 256,
   parameter int LIMIT_MAX  = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [efrs_pkg::ACTION_W-1:0]  req_action,
   input  wire logic [efrs_pkg::FLOW_W-1:0]    req_flow_id,
   output logic                                rsp_valid,
   output logic      [efrs_pkg::CMD_W-1:0]     rsp_command,
   output logic      [efrs_pkg::FLOW_W-1:0]    rsp_target_flow,
   output logic                                rsp_last,
   input  wire logic                           csr_wr_en,
   input  wire logic [efrs_pkg::LIMIT_W-1:0]   csr_wr_data
);

   import efrs_pkg::*;

   // The active FIFO fills only below the effective limit, at most its depth, so it never wraps.
   localparam int ACT_DEPTH = (LIMIT_MAX < FLOW_SLOTS) ? LIMIT_MAX : FLOW_SLOTS;
   localparam int LIM_W     = $clog2(ACT_DEPTH + 1);
   localparam int AA_W      = $clog2(2 * ACT_DEPTH);
   localparam int PA_W      = $clog2(FLOW_SLOTS);
   localparam int PC_W      = $clog2(FLOW_SLOTS + 1);
   localparam int LA_W      = $clog2(LIVE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OPEN,
      ST_ACT_RD,
      ST_ACT_LIVE,
      ST_ACT_DEC,
      ST_PAU_RD,
      ST_PAU_LIVE,
      ST_PAU_DEC
   } state_type;

   // Registers and their next values.
   state_type         state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic              bank_ff, bank_in;
   logic [LIM_W-1:0]  acount_ff, acount_in;
   logic [LIM_W-1:0]  nprev_ff, nprev_in;
   logic [LIM_W-1:0]  idx_ff, idx_in;
   logic [PA_W-1:0]   phead_ff, phead_in;
   logic [PA_W-1:0]   ptail_ff, ptail_in;
   logic [PC_W-1:0]   pcount_ff, pcount_in;
   logic [FLOW_W-1:0] flow_ff, flow_in;
   logic [LIVE_DEPTH-1:0] live_vld_ff, live_vld_in;
   logic              live_vld_q_ff, live_vld_q_in;
   logic              pend_valid_ff, pend_valid_in;
   command_type       pend_cmd_ff, pend_cmd_in;
   logic [FLOW_W-1:0] pend_flow_ff, pend_flow_in;
   logic              rsp_valid_ff, rsp_valid_in;
   command_type       rsp_cmd_ff, rsp_cmd_in;
   logic [FLOW_W-1:0] rsp_flow_ff, rsp_flow_in;
   logic              rsp_last_ff, rsp_last_in;

   // RAM ports.
   logic              a_we, a_re;
   logic [AA_W-1:0]   a_waddr, a_raddr;
   logic [FLOW_W-1:0] a_wdata, a_rdata;
   logic              p_we, p_re;
   logic [PA_W-1:0]   p_waddr, p_raddr;
   logic [FLOW_W-1:0] p_wdata, p_rdata;
   logic              l_we, l_re;
   logic [LA_W-1:0]   l_waddr, l_raddr;
   logic [0:0]        l_wdata, l_rdata;

   // Working signals.
   logic              live_q;
   logic [LIM_W-1:0]  eff_lim;
   logic              tick_emit;
   command_type       tick_cmd;
   logic [FLOW_W-1:0] tick_flow;

   // Active FIFO in two banks: a tick reads the old bank while it refills the other.
   efrs_ram #(.WIDTH(FLOW_W), .DEPTH(2 * ACT_DEPTH)) u_active_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_en   (a_re),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   // Paused FIFO, circular.
   efrs_ram #(.WIDTH(FLOW_W), .DEPTH(FLOW_SLOTS)) u_paused_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_en   (p_re),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   // Live map; an entry never written since reset reads as not live.
   efrs_ram #(.WIDTH(1), .DEPTH(LIVE_DEPTH)) u_live_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (l_wdata),
      .rd_en   (l_re),
      .rd_addr (l_raddr),
      .rd_data (l_rdata)
   );

   assign live_q = live_vld_q_ff & l_rdata[0];

   // Effective limit: zero acts as one, and it is capped at the active FIFO depth.
   always_comb begin
      if (limit_ff == '0) begin
         eff_lim = LIM_W'(1);
      end else if ((LIMIT_W + 1)'(limit_ff) > (LIMIT_W + 1)'(ACT_DEPTH)) begin
         eff_lim = LIM_W'(ACT_DEPTH);
      end else begin
         eff_lim = LIM_W'(limit_ff);
      end
   end

   // Sequencer: next state, FIFO pointers, RAM accesses and results.
   always_comb begin
      state_in      = state_ff;
      limit_in      = limit_ff;
      bank_in       = bank_ff;
      acount_in     = acount_ff;
      nprev_in      = nprev_ff;
      idx_in        = idx_ff;
      phead_in      = phead_ff;
      ptail_in      = ptail_ff;
      pcount_in     = pcount_ff;
      flow_in       = flow_ff;
      live_vld_in   = live_vld_ff;
      live_vld_q_in = live_vld_q_ff;
      pend_valid_in = pend_valid_ff;
      pend_cmd_in   = pend_cmd_ff;
      pend_flow_in  = pend_flow_ff;
      rsp_valid_in  = 1'b0;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_flow_in   = rsp_flow_ff;
      rsp_last_in   = rsp_last_ff;
      a_we = 1'b0;  a_waddr = '0;  a_wdata = flow_ff;
      a_re = 1'b0;  a_raddr = '0;
      p_we = 1'b0;  p_waddr = ptail_ff;  p_wdata = flow_ff;
      p_re = 1'b0;  p_raddr = phead_ff;
      l_we = 1'b0;  l_waddr = flow_ff;  l_wdata = 1'b0;
      l_re = 1'b0;  l_raddr = flow_ff;
      tick_emit = 1'b0;
      tick_cmd  = CMD_ACTIVATE;
      tick_flow = flow_ff;

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_action)
                  ACTION_OPEN: begin
                     l_re     = 1'b1;
                     l_raddr  = req_flow_id;
                     flow_in  = req_flow_id;
                     state_in = ST_OPEN;
                  end
                  ACTION_CLOSE: begin
                     l_we         = 1'b1;
                     l_waddr      = req_flow_id;
                     l_wdata      = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_cmd_in   = CMD_RELEASED;
                     rsp_flow_in  = req_flow_id;
                     rsp_last_in  = 1'b1;
                  end
                  ACTION_TICK: begin
                     // A tick with a free active slot and nothing paused does nothing.
                     if (!(acount_ff < eff_lim && pcount_ff == '0)) begin
                        nprev_in  = acount_ff;
                        bank_in   = ~bank_ff;
                        acount_in = '0;
                        idx_in    = '0;
                        state_in  = ST_ACT_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_OPEN: begin
            rsp_valid_in = 1'b1;
            rsp_flow_in  = flow_ff;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
            if (live_q) begin
               rsp_cmd_in = CMD_REJECTED;
            end else if (acount_ff < eff_lim) begin
               a_we       = 1'b1;
               a_waddr    = AA_W'(acount_ff) + (bank_ff ? AA_W'(ACT_DEPTH) : AA_W'(0));
               acount_in  = acount_ff + LIM_W'(1);
               l_we       = 1'b1;
               l_wdata    = 1'b1;
               rsp_cmd_in = CMD_PLACED;
            end else if (pcount_ff < PC_W'(FLOW_SLOTS)) begin
               p_we       = 1'b1;
               ptail_in   = (ptail_ff == PA_W'(FLOW_SLOTS - 1)) ? '0 : ptail_ff + PA_W'(1);
               pcount_in  = pcount_ff + PC_W'(1);
               l_we       = 1'b1;
               l_wdata    = 1'b1;
               rsp_cmd_in = CMD_PAUSE;
            end else begin
               rsp_cmd_in = CMD_REJECTED;
            end
         end

         // Activation walk: pop paused entries until the limit is reached or the paused FIFO is empty.
         ST_ACT_RD: begin
            if (pcount_ff != '0 && acount_ff < eff_lim) begin
               p_re      = 1'b1;
               phead_in  = (phead_ff == PA_W'(FLOW_SLOTS - 1)) ? '0 : phead_ff + PA_W'(1);
               pcount_in = pcount_ff - PC_W'(1);
               state_in  = ST_ACT_LIVE;
            end else begin
               state_in = ST_PAU_RD;
            end
         end

         ST_ACT_LIVE: begin
            l_re     = 1'b1;
            l_raddr  = p_rdata;
            flow_in  = p_rdata;
            state_in = ST_ACT_DEC;
         end

         ST_ACT_DEC: begin
            if (live_q) begin
               a_we      = 1'b1;
               a_waddr   = AA_W'(acount_ff) + (bank_ff ? AA_W'(ACT_DEPTH) : AA_W'(0));
               acount_in = acount_ff + LIM_W'(1);
               tick_emit = 1'b1;
               tick_cmd  = CMD_ACTIVATE;
            end
            state_in = ST_ACT_RD;
         end

         // Pause walk over the previously active entries in the old bank.
         ST_PAU_RD: begin
            if (idx_ff < nprev_ff) begin
               a_re     = 1'b1;
               a_raddr  = AA_W'(idx_ff) + (bank_ff ? AA_W'(0) : AA_W'(ACT_DEPTH));
               idx_in   = idx_ff + LIM_W'(1);
               state_in = ST_PAU_LIVE;
            end else begin
               // The held result is the final one of this tick.
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_cmd_in   = pend_cmd_ff;
                  rsp_flow_in  = pend_flow_ff;
                  rsp_last_in  = 1'b1;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_PAU_LIVE: begin
            l_re     = 1'b1;
            l_raddr  = a_rdata;
            flow_in  = a_rdata;
            state_in = ST_PAU_DEC;
         end

         ST_PAU_DEC: begin
            if (live_q) begin
               tick_emit = 1'b1;
               if (pcount_ff < PC_W'(FLOW_SLOTS)) begin
                  p_we      = 1'b1;
                  ptail_in  = (ptail_ff == PA_W'(FLOW_SLOTS - 1)) ? '0 : ptail_ff + PA_W'(1);
                  pcount_in = pcount_ff + PC_W'(1);
                  tick_cmd  = CMD_PAUSE;
               end else begin
                  l_we     = 1'b1;
                  l_wdata  = 1'b0;
                  tick_cmd = CMD_RELEASED;
               end
            end
            state_in = ST_PAU_RD;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A tick holds back one result, so that the final one can be marked last.
      if (tick_emit) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_cmd_in   = pend_cmd_ff;
            rsp_flow_in  = pend_flow_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_cmd_in   = tick_cmd;
         pend_flow_in  = tick_flow;
      end

      // Live-map valid bits follow every write; a read samples the addressed bit.
      if (l_we) begin
         live_vld_in[l_waddr] = 1'b1;
      end
      if (l_re) begin
         live_vld_q_in = live_vld_ff[l_raddr];
      end
   end

   // State, counters and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         limit_ff      <= LIMIT_W'(1);
         bank_ff       <= 1'b0;
         acount_ff     <= '0;
         nprev_ff      <= '0;
         idx_ff        <= '0;
         phead_ff      <= '0;
         ptail_ff      <= '0;
         pcount_ff     <= '0;
         live_vld_ff   <= '0;
         live_vld_q_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         bank_ff       <= bank_in;
         acount_ff     <= acount_in;
         nprev_ff      <= nprev_in;
         idx_ff        <= idx_in;
         phead_ff      <= phead_in;
         ptail_ff      <= ptail_in;
         pcount_ff     <= pcount_in;
         live_vld_ff   <= live_vld_in;
         live_vld_q_ff <= live_vld_q_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      flow_ff      <= flow_in;
      pend_cmd_ff  <= pend_cmd_in;
      pend_flow_ff <= pend_flow_in;
      rsp_cmd_ff   <= rsp_cmd_in;
      rsp_flow_ff  <= rsp_flow_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = rsp_cmd_ff;
   assign rsp_target_flow = rsp_flow_ff;
   assign rsp_last        = rsp_last_ff;

   // The active FIFO never grows past its depth.
   assert property (@(posedge clock) disable iff (reset)
      acount_ff <= LIM_W'(ACT_DEPTH))
      else $error("active count exceeds active FIFO depth");

   // The paused FIFO never grows past its depth.
   assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= PC_W'(FLOW_SLOTS))
      else $error("paused count exceeds paused FIFO depth");

   // A result that is not the final one only appears while a tick is still running.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final result outside a tick");

   // A held-back result never outlives its tick.
   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> busy)
      else $error("held result left pending while idle");

endmodule : epoch_flow_rotation_scheduler

`default_nettype wire
